// File: hw/rtl/dda_pkg.sv
// shared types, constants and codes for the dda line rasterizer
// no dependencies; imported by every rtl file of the block
package dda_pkg;

  // geometry and fixed-point format
  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned POS_W      = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned STEP_W     = FRAC_BITS + 2;
  localparam int unsigned QUOT_W     = FRAC_BITS + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(FRAC_BITS + 1);

  // color and configuration widths
  localparam int unsigned COLOR_W   = 4;
  localparam int unsigned HOLD_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 4;

  // register reset values
  localparam logic [CFG_W-1:0] COLOR_HOLD_RST   = 4'd10;
  localparam logic [CFG_W-1:0] PALETTE_SIZE_RST = 4'd15;
  localparam logic [CFG_W-1:0] FIRST_COLOR_RST  = 4'd1;
  localparam logic [COLOR_W-1:0] COLOR_INDEX_RST = 4'd1;

  // command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_HOLD   = 2'd0,
    CFG_PALETTE_SIZE = 2'd1,
    CFG_FIRST_COLOR  = 2'd2
  } cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_SIGN,
    ST_ADV
  } state_e;

  // input transaction
  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_W-1:0]    color;
    logic                  last;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic add_pos;
    logic emit_load;
    logic div_step;
    logic apply_sign;
    logic emit_adv;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic drawing;
    logic steps_zero;
    logic div_last;
    logic out_free;
    logic final_pixel;
  } dp_status_t;

endpackage

// File: hw/rtl/dda_div.sv
// one lane of the radix-2 restoring divider: floor(dividend * 2^FRAC_BITS / divisor)
// depends on dda_pkg; requires dividend <= divisor and divisor > 0
module dda_div (
  input  logic                           clk_i,
  input  logic                           start_i,
  input  logic                           step_i,
  input  logic                           first_i,
  input  logic [dda_pkg::COORD_BITS-1:0] dividend_i,
  input  logic [dda_pkg::COORD_BITS-1:0] divisor_i,
  output logic [dda_pkg::QUOT_W-1:0]     quot_o
);
  import dda_pkg::*;

  logic [COORD_BITS:0]   rem_q, rem_d;
  logic [QUOT_W-1:0]     quot_q, quot_d;
  logic [COORD_BITS:0]   trial;
  logic                  ge;

  // partial remainder: integer bit first, then one fraction bit per step
  always_comb begin
    trial = first_i ? rem_q : {rem_q[COORD_BITS-1:0], 1'b0};
    ge    = trial >= {1'b0, divisor_i};
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      rem_d  = {1'b0, dividend_i};
      quot_d = '0;
    end else if (step_i) begin
      rem_d  = ge ? (trial - {1'b0, divisor_i}) : trial;
      quot_d = {quot_q[QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;

endmodule

// File: hw/rtl/dda_dp.sv
// datapath of the dda line rasterizer: config registers, line state, dividers, output register
// depends on dda_pkg and dda_div; driven by dda_ctrl commands
module dda_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dda_pkg::in_t                  in_data_i,
  input  dda_pkg::ctrl_cmd_t            cmd_i,
  output dda_pkg::dp_status_t           status_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dda_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dda_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dda_pkg::CFG_W-1:0]     cfg_data_i
);
  import dda_pkg::*;

  // remainder of a small value by the palette size, four-bit divisor
  function automatic logic [COLOR_W-1:0] mod_ps(logic [4:0] v, logic [CFG_W-1:0] ps);
    logic [8:0] r;
    logic [8:0] d;
    r = {4'b0, v};
    for (int i = 4; i >= 0; i--) begin
      d = 9'({5'b0, ps} << i);
      if (r >= d) r = r - d;
    end
    return r[COLOR_W-1:0];
  endfunction

  // configuration registers
  logic [CFG_W-1:0] color_hold_q, palette_size_q, first_color_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_hold_q   <= COLOR_HOLD_RST;
      palette_size_q <= PALETTE_SIZE_RST;
      first_color_q  <= FIRST_COLOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COLOR_HOLD:   color_hold_q   <= cfg_data_i;
        CFG_PALETTE_SIZE: palette_size_q <= cfg_data_i;
        CFG_FIRST_COLOR:  first_color_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured input transaction
  in_t in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_data_i;
  end

  // deltas, magnitudes and step count of the captured line
  logic [COORD_BITS:0]   dx, dy, ax_full, ay_full;
  logic [COORD_BITS-1:0] ax, ay, steps;

  always_comb begin
    dx      = {1'b0, in_q.x_end} - {1'b0, in_q.x_start};
    dy      = {1'b0, in_q.y_end} - {1'b0, in_q.y_start};
    ax_full = dx[COORD_BITS] ? -dx : dx;
    ay_full = dy[COORD_BITS] ? -dy : dy;
    ax      = ax_full[COORD_BITS-1:0];
    ay      = ay_full[COORD_BITS-1:0];
    steps   = (ax > ay) ? ax : ay;
  end

  // line state
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
  logic signed [STEP_W-1:0] step_x_q, step_y_q;
  logic [COORD_BITS-1:0]    steps_q, steps_left_q;
  logic                     neg_x_q, neg_y_q, drawing_q;
  logic [COLOR_W-1:0]       color_index_q;
  logic [HOLD_W-1:0]        hold_q;
  logic [DIV_CNT_W-1:0]     div_cnt_q;
  logic [QUOT_W-1:0]        quot_x, quot_y;

  // division lanes for the x and y increments
  dda_div u_div_x (
    .clk_i      (clk_i),
    .start_i    (cmd_i.emit_load),
    .step_i     (cmd_i.div_step),
    .first_i    (div_cnt_q == '0),
    .dividend_i (ax),
    .divisor_i  (steps_q),
    .quot_o     (quot_x)
  );

  dda_div u_div_y (
    .clk_i      (clk_i),
    .start_i    (cmd_i.emit_load),
    .step_i     (cmd_i.div_step),
    .first_i    (div_cnt_q == '0),
    .dividend_i (ay),
    .divisor_i  (steps_q),
    .quot_o     (quot_y)
  );

  // rounded pixel position, negative positions clamp to zero
  logic [COORD_BITS+FRAC_BITS-1:0] half, sum_x, sum_y;
  logic [COORD_BITS-1:0]           rnd_x, rnd_y;

  always_comb begin
    half  = (COORD_BITS+FRAC_BITS)'(1) << (FRAC_BITS - 1);
    sum_x = pos_x_q[COORD_BITS+FRAC_BITS-1:0] + half;
    sum_y = pos_y_q[COORD_BITS+FRAC_BITS-1:0] + half;
    rnd_x = pos_x_q[POS_W-1] ? '0 : sum_x[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
    rnd_y = pos_y_q[POS_W-1] ? '0 : sum_y[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
  end

  // palette color and next color index
  logic [COLOR_W-1:0] pal_color, ci_next;
  logic               hold_hit;

  always_comb begin
    pal_color = (palette_size_q == '0) ? color_index_q
                                       : mod_ps({1'b0, color_index_q}, palette_size_q);
    ci_next   = (palette_size_q == '0) ? color_index_q + 1'b1
                                       : mod_ps({1'b0, color_index_q} + 5'd1, palette_size_q);
    hold_hit  = hold_q > {1'b0, color_hold_q};
  end

  // signed increments from quotient magnitudes
  logic signed [STEP_W-1:0] inc_x, inc_y;

  always_comb begin
    inc_x = neg_x_q ? -$signed({1'b0, quot_x}) : $signed({1'b0, quot_x});
    inc_y = neg_y_q ? -$signed({1'b0, quot_y}) : $signed({1'b0, quot_y});
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      step_x_q      <= '0;
      step_y_q      <= '0;
      steps_q       <= '0;
      steps_left_q  <= '0;
      neg_x_q       <= 1'b0;
      neg_y_q       <= 1'b0;
      drawing_q     <= 1'b0;
      color_index_q <= COLOR_INDEX_RST;
      hold_q        <= '0;
      div_cnt_q     <= '0;
    end else begin
      if (cmd_i.emit_load) begin
        pos_x_q       <= $signed({1'b0, in_q.x_start, FRAC_BITS'(0)});
        pos_y_q       <= $signed({1'b0, in_q.y_start, FRAC_BITS'(0)});
        step_x_q      <= '0;
        step_y_q      <= '0;
        steps_q       <= steps;
        steps_left_q  <= steps;
        neg_x_q       <= dx[COORD_BITS];
        neg_y_q       <= dy[COORD_BITS];
        drawing_q     <= steps != '0;
        color_index_q <= COLOR_INDEX_RST;
        hold_q        <= '0;
        div_cnt_q     <= '0;
      end
      if (cmd_i.div_step) div_cnt_q <= div_cnt_q + 1'b1;
      if (cmd_i.apply_sign) begin
        step_x_q <= inc_x;
        step_y_q <= inc_y;
      end
      if (cmd_i.add_pos) begin
        pos_x_q <= pos_x_q + {{(POS_W-STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
        pos_y_q <= pos_y_q + {{(POS_W-STEP_W){step_y_q[STEP_W-1]}}, step_y_q};
      end
      if (cmd_i.emit_adv) begin
        steps_left_q <= steps_left_q - 1'b1;
        if (steps_left_q == COORD_BITS'(1)) drawing_q <= 1'b0;
        if (hold_hit) begin
          color_index_q <= ci_next;
          hold_q        <= HOLD_W'(1);
        end else begin
          hold_q <= hold_q + 1'b1;
        end
      end
    end
  end

  // output register
  logic out_valid_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.emit_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_q.pixel_x <= in_q.x_start;
      out_q.pixel_y <= in_q.y_start;
      out_q.color   <= first_color_q;
      out_q.last    <= steps == '0;
    end else if (cmd_i.emit_adv) begin
      out_q.pixel_x <= rnd_x;
      out_q.pixel_y <= rnd_y;
      out_q.color   <= pal_color;
      out_q.last    <= steps_left_q == COORD_BITS'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status toward the controller
  always_comb begin
    status_o.drawing     = drawing_q;
    status_o.steps_zero  = steps == '0;
    status_o.div_last    = div_cnt_q == DIV_CNT_W'(FRAC_BITS);
    status_o.out_free    = !out_valid_q || !out_stall_i;
    status_o.final_pixel = steps_left_q == COORD_BITS'(1);
  end

endmodule

// File: hw/rtl/dda_ctrl.sv
// controller state machine of the dda line rasterizer
// depends on dda_pkg; issues commands to dda_dp and reads its status
module dda_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                command_i,
  output logic                in_stall_o,
  input  dda_pkg::dp_status_t status_i,
  output dda_pkg::ctrl_cmd_t  cmd_o,
  output dda_pkg::state_e     state_o
);
  import dda_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_LOAD) state_d = ST_LOAD;
          else if (status_i.drawing) state_d = ST_ADV;
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) state_d = status_i.steps_zero ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_SIGN;
      end
      ST_SIGN: state_d = ST_IDLE;
      ST_ADV: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = state_q != ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = accept;
        cmd_o.add_pos = accept && (command_i == CMD_ADVANCE) && status_i.drawing;
      end
      ST_LOAD:  cmd_o.emit_load  = status_i.out_free;
      ST_DIV:   cmd_o.div_step   = 1'b1;
      ST_SIGN:  cmd_o.apply_sign = 1'b1;
      ST_ADV:   cmd_o.emit_adv   = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign state_o = state_q;

endmodule

// File: hw/rtl/dda_line_rasterizer.sv
// top level of the dda line rasterizer: controller plus datapath
// depends on dda_pkg, dda_ctrl, dda_dp and dda_div
//
// Usage: the input channel (in_valid_i / in_stall_o / in_data_i) takes one
// command per transaction. A load (command 0) carries both endpoints and
// yields the first pixel; an advance (command 1) yields the next pixel of
// the current line, or nothing when no line is in progress. Pixels leave on
// the output channel (out_valid_o / out_stall_i / out_data_o); last marks
// the endpoint. Three 4-bit registers (color hold, palette size, first
// color) are written through cfg_valid_i / cfg_ready_o, index and data.
// Sequence: a load is accepted, then finds the deltas and emits the first
// pixel once the output register is free, then runs the bit-serial
// increment divider and finally applies the signs. A zero-length load
// goes back to idle after its first pixel, without divider or signs. An
// advance adds the position in its acceptance cycle, then rounds it into
// the output register once that is free. The first pixel of a load is
// written in the load state, an advance pixel in the advance state.
// Reset clears the line state, sets the registers to 10, 15 and 1, and
// leaves the block idle. While the receiver stalls, the pending pixel holds
// and a command that needs to emit waits; in_stall_o stays high meanwhile.
module dda_line_rasterizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dda_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dda_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dda_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dda_pkg::CFG_W-1:0]     cfg_data_i
);
  import dda_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  state_e     state;

  // sequencing
  dda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (in_data_i.command),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  // arithmetic and storage
  dda_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

`ifndef SYNTHESIS
  // an accepted load keeps the input side busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.command == CMD_LOAD) |=> in_stall_o)
    else $error("load transaction did not occupy the block");

  // emitting the endpoint pixel ends the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_adv && status.final_pixel |=> !status.drawing)
    else $error("line still drawing after its last pixel");

  // the divider stops after its final quotient bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step && status.div_last |=> !cmd.div_step && (state == ST_SIGN))
    else $error("divider ran past its final step");

  // a pixel is only written into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_load || cmd.emit_adv) |-> status.out_free)
    else $error("pixel emitted over a stalled output");
`endif

endmodule

// File: sim/dda_line_rasterizer_tb.sv
// testbench for the dda line rasterizer: a directed table, then random lines under three idling modes
// depends on dda_pkg and dda_line_rasterizer; pixels checked by a local line tracer or a pinned row
module dda_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dda_pkg::*;

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int LEFT_W      = COORD_BITS + 1;
  localparam int SETTLE      = FRAC_BITS + 12;
  localparam int HOLD_OFF    = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LINE_QUOTA  = 135;

  // one row of the directed table; pinned rows carry the pixel read off by hand
  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic                  pinned;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_W-1:0]    color;
    logic                  last;
  } probe_t;

  localparam probe_t PROBES [25] = '{
    // advance with no line in progress
    '{CMD_ADVANCE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    // zero-length lines at both corners
    '{CMD_LOAD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 10'd0, 10'd0, FIRST_COLOR_RST, 1'b1},
    '{CMD_LOAD, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
      1'b1, 10'd1023, 10'd1023, FIRST_COLOR_RST, 1'b1},
    // full diagonal, abandoned by a load of the other diagonal
    '{CMD_LOAD, 10'd0, 10'd0, 10'd1023, 10'd1023, 1'b1, 10'd0, 10'd0, FIRST_COLOR_RST, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd1023, 10'd0, 10'd1023, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_LOAD, 10'd1023, 10'd0, 10'd0, 10'd1023,
      1'b1, 10'd1023, 10'd0, FIRST_COLOR_RST, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd1023, 10'd0, 10'd1023, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    // short horizontal line, whole steps
    '{CMD_LOAD, 10'd5, 10'd5, 10'd8, 10'd5, 1'b1, 10'd5, 10'd5, FIRST_COLOR_RST, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 10'd6, 10'd5, 4'd1, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 10'd7, 10'd5, 4'd1, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 10'd8, 10'd5, 4'd1, 1'b1},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    // fractional increment, truncated and rounded
    '{CMD_LOAD, 10'd0, 10'd0, 10'd3, 10'd1, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    // negative deltas on both axes
    '{CMD_LOAD, 10'd10, 10'd10, 10'd7, 10'd3, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0},
    '{CMD_ADVANCE, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 10'd0, 4'd0, 1'b0}
  };

  // clock, reset and block ports
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_e         cfg_index = CFG_COLOR_HOLD;
  logic [CFG_W-1:0] cfg_data  = '0;

  // hand-read pixel travelling alongside the offered command
  logic pin_valid = 1'b0;
  out_t pin_data  = '0;

  // idling control
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int          hold_reqs    = 0;
  int          hold_seen    = 0;
  int          hold_left    = 0;

  int   cycles     = 0;
  int   mismatches = 0;
  out_t pending_pixels [$];

  // line tracer state
  logic signed [POS_W-1:0]  ln_pos_x, ln_pos_y;
  logic signed [STEP_W-1:0] ln_step_x, ln_step_y;
  logic [LEFT_W-1:0]        ln_left;
  logic [COLOR_W-1:0]       ln_color_idx;
  logic [HOLD_W-1:0]        ln_hold_cnt;
  logic                     ln_drawing;
  logic [CFG_W-1:0]         reg_color_hold, reg_palette, reg_first_color;

  always #5 clk = ~clk;

  dda_line_rasterizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // signed per-pixel increment, magnitude truncated before the sign is applied
  function automatic logic signed [STEP_W-1:0] increment(input int d, input int span);
    int unsigned mag;
    int unsigned q;
    if (span == 0) return '0;
    mag = (d < 0) ? -d : d;
    q = (mag << FRAC_BITS) / span;
    return (d < 0) ? -STEP_W'(q) : STEP_W'(q);
  endfunction

  // round a fixed-point position to the nearest pixel, negatives clamp to zero
  function automatic logic [COORD_BITS-1:0] nearest(input logic signed [POS_W-1:0] p);
    logic [POS_W:0] v;
    v = p[POS_W-1] ? '0 : {2'b00, p[POS_W-2:0]};
    v = v + (POS_W+1)'(1 << (FRAC_BITS - 1));
    return v[FRAC_BITS +: COORD_BITS];
  endfunction

  function automatic logic [COLOR_W-1:0] shade(input logic [COLOR_W-1:0] idx);
    if (reg_palette == '0) return idx;
    return idx % reg_palette;
  endfunction

  // advance the tracer by one command; returns 1 when a pixel comes out
  function automatic logic trace_pixel(input in_t cmd, output out_t pix);
    int dx, dy, adx, ady, span;
    logic [COLOR_W:0] next_idx;
    pix = '0;
    if (cmd.command == CMD_LOAD) begin
      dx   = int'(cmd.x_end) - int'(cmd.x_start);
      dy   = int'(cmd.y_end) - int'(cmd.y_start);
      adx  = (dx < 0) ? -dx : dx;
      ady  = (dy < 0) ? -dy : dy;
      span = (adx > ady) ? adx : ady;
      ln_pos_x     = $signed({1'b0, cmd.x_start, {FRAC_BITS{1'b0}}});
      ln_pos_y     = $signed({1'b0, cmd.y_start, {FRAC_BITS{1'b0}}});
      ln_step_x    = increment(dx, span);
      ln_step_y    = increment(dy, span);
      ln_left      = LEFT_W'(span);
      ln_drawing   = (span != 0);
      ln_color_idx = COLOR_INDEX_RST;
      ln_hold_cnt  = '0;
      pix.pixel_x  = cmd.x_start;
      pix.pixel_y  = cmd.y_start;
      pix.color    = reg_first_color;
      pix.last     = (span == 0);
      return 1'b1;
    end
    if (!ln_drawing) return 1'b0;
    ln_pos_x    = ln_pos_x + POS_W'(ln_step_x);
    ln_pos_y    = ln_pos_y + POS_W'(ln_step_y);
    ln_left     = ln_left - 1'b1;
    pix.pixel_x = nearest(ln_pos_x);
    pix.pixel_y = nearest(ln_pos_y);
    pix.color   = shade(ln_color_idx);
    pix.last    = (ln_left == '0);
    if (ln_left == '0) ln_drawing = 1'b0;
    // color index moves on once the hold counter passes the threshold
    if (ln_hold_cnt > HOLD_W'(reg_color_hold)) begin
      next_idx     = {1'b0, ln_color_idx} + 1'b1;
      ln_color_idx = (reg_palette == '0) ? next_idx[COLOR_W-1:0]
                                         : COLOR_W'(next_idx % reg_palette);
      ln_hold_cnt  = '0;
    end
    ln_hold_cnt = ln_hold_cnt + 1'b1;
    return 1'b1;
  endfunction

  function automatic in_t random_cmd(input logic command);
    in_t c;
    c.command = command;
    c.x_start = COORD_BITS'($urandom_range(COORD_MAX));
    c.y_start = COORD_BITS'($urandom_range(COORD_MAX));
    c.x_end   = COORD_BITS'($urandom_range(COORD_MAX));
    c.y_end   = COORD_BITS'($urandom_range(COORD_MAX));
    return c;
  endfunction

  // endpoint within span of s, reflected back into the screen
  function automatic int far_end(input int s, input int span);
    int e;
    e = $urandom_range(1) ? s + int'($urandom_range(span)) : s - int'($urandom_range(span));
    if (e < 0) e = -e;
    if (e > COORD_MAX) e = 2 * COORD_MAX - e;
    return e;
  endfunction

  // track config writes, predict on accepted commands, check accepted pixels
  always @(posedge clk or negedge rst_n) begin
    out_t traced;
    out_t want;
    logic emits;
    if (!rst_n) begin
      reg_color_hold  = COLOR_HOLD_RST;
      reg_palette     = PALETTE_SIZE_RST;
      reg_first_color = FIRST_COLOR_RST;
      ln_pos_x        = '0;
      ln_pos_y        = '0;
      ln_step_x       = '0;
      ln_step_y       = '0;
      ln_left         = '0;
      ln_color_idx    = COLOR_INDEX_RST;
      ln_hold_cnt     = '0;
      ln_drawing      = 1'b0;
      pending_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COLOR_HOLD:   reg_color_hold  = cfg_data;
          CFG_PALETTE_SIZE: reg_palette     = cfg_data;
          CFG_FIRST_COLOR:  reg_first_color = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        emits = trace_pixel(in_data, traced);
        if (pin_valid) pending_pixels.push_back(pin_data);
        else if (emits) pending_pixels.push_back(traced);
      end
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel: x=%0d y=%0d color=%0d last=%0b",
                     out_data.pixel_x, out_data.pixel_y, out_data.color, out_data.last);
        end else begin
          want = pending_pixels.pop_front();
          if (out_data.pixel_x !== want.pixel_x || out_data.pixel_y !== want.pixel_y ||
              out_data.color !== want.color || out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected x=%0d y=%0d color=%0d last=%0b, got x=%0d y=%0d color=%0d last=%0b",
                       want.pixel_x, want.pixel_y, want.color, want.last,
                       out_data.pixel_x, out_data.pixel_y, out_data.color, out_data.last);
          end
        end
      end
    end
  end

  // receiver stall: random, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_OFF;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // offer one command after a random gap and hold it until accepted
  task automatic send_cmd(input in_t cmd, input logic pinned, input out_t pix);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= cmd;
    pin_valid <= pinned;
    pin_data  <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // drain, then give a pending divide time to finish
  task automatic settle();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_colors(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] palette,
                            input logic [CFG_W-1:0] first);
    cfg_idx_e         idx [3];
    logic [CFG_W-1:0] val [3];
    idx = '{CFG_COLOR_HOLD, CFG_PALETTE_SIZE, CFG_FIRST_COLOR};
    val = '{hold, palette, first};
    cfg_valid <= 1'b1;
    for (int r = 0; r < 3; r++) begin
      cfg_index <= idx[r];
      cfg_data  <= val[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // random lines: mostly short and completed, some abandoned, a few screen-wide
  task automatic random_lines(input int quota, input bit pause_midway);
    in_t cmd;
    int  sent, kind, span, xs, ys, xe, ye, adx, ady, steps, advances;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < quota) begin
      kind = $urandom_range(99);
      span = (kind < 80) ? 12 : (kind < 95) ? 80 : COORD_MAX;
      xs   = $urandom_range(COORD_MAX);
      ys   = $urandom_range(COORD_MAX);
      xe   = far_end(xs, span);
      ye   = ($urandom_range(9) == 0) ? ys : far_end(ys, span);
      cmd  = random_cmd(CMD_LOAD);
      cmd.x_start = COORD_BITS'(xs);
      cmd.y_start = COORD_BITS'(ys);
      cmd.x_end   = COORD_BITS'(xe);
      cmd.y_end   = COORD_BITS'(ye);
      adx   = (xe > xs) ? xe - xs : xs - xe;
      ady   = (ye > ys) ? ye - ys : ys - ye;
      steps = (adx > ady) ? adx : ady;
      if (span == COORD_MAX && $urandom_range(99) >= 15)
        advances = $urandom_range((steps < 40) ? steps : 40);
      else if ($urandom_range(99) < 75)
        advances = steps + $urandom_range(2);
      else
        advances = $urandom_range(steps);
      send_cmd(cmd, 1'b0, '0);
      for (int k = 0; k < advances; k++) send_cmd(random_cmd(CMD_ADVANCE), 1'b0, '0);
      sent += 1 + ((advances < steps) ? advances : steps);
      // sender pause until the output side has caught up
      if (pause_midway && !paused && sent >= quota / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      // stray command between lines
      if ($urandom_range(99) < 5) send_cmd(random_cmd(1'($urandom_range(1))), 1'b0, '0);
    end
  endtask

  // main sequence
  initial begin
    in_t  cmd;
    out_t pin;
    send_gap_pct = 25;
    recv_gap_pct <= 66;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table on reset register values
    foreach (PROBES[i]) begin
      cmd.command = PROBES[i].command;
      cmd.x_start = PROBES[i].x_start;
      cmd.y_start = PROBES[i].y_start;
      cmd.x_end   = PROBES[i].x_end;
      cmd.y_end   = PROBES[i].y_end;
      pin.pixel_x = PROBES[i].pixel_x;
      pin.pixel_y = PROBES[i].pixel_y;
      pin.color   = PROBES[i].color;
      pin.last    = PROBES[i].last;
      send_cmd(cmd, PROBES[i].pinned, pin);
    end

    // low extremes: zero color hold, single-entry palette
    settle();
    set_colors(4'd0, 4'd1, 4'd0);
    random_lines(LINE_QUOTA, 1'b0);

    // high extremes with a long receiver hold-off
    settle();
    set_colors(4'd15, 4'd15, 4'd15);
    hold_reqs <= hold_reqs + 1;
    random_lines(LINE_QUOTA, 1'b0);

    // sender idles more than receiver; palette size zero wraps at sixteen
    send_gap_pct = 66;
    recv_gap_pct <= 25;
    settle();
    set_colors(4'd2, 4'd0, 4'd9);
    random_lines(LINE_QUOTA, 1'b1);

    settle();
    set_colors(CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15, 1)),
               CFG_W'($urandom_range(15)));
    random_lines(LINE_QUOTA, 1'b0);

    // back to back, no idling on either side
    send_gap_pct = 0;
    recv_gap_pct <= 0;
    settle();
    set_colors(CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)),
               CFG_W'($urandom_range(15)));
    random_lines(LINE_QUOTA, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dda_pkg.sv
hw/rtl/dda_div.sv
hw/rtl/dda_dp.sv
hw/rtl/dda_ctrl.sv
hw/rtl/dda_line_rasterizer.sv
sim/dda_line_rasterizer_tb.sv
